### rtl/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types, constants and fixed-point helpers for the angular density
// polynomial unit.
// ----------------------------------------------------------------------------
package adp_pkg;

  typedef enum logic [2:0] {
    OP_DENSITY  = 3'd0,
    OP_PRIM_C0  = 3'd1,
    OP_PRIM_C1  = 3'd2,
    OP_PRIM_C2  = 3'd3,
    OP_PRIM_C01 = 3'd4,
    OP_PRIM_C02 = 3'd5,
    OP_PRIM_C12 = 3'd6,
    OP_PRIM_ALL = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    REG_POLARISATION = 3'd0,
    REG_DECAY_ASYM   = 3'd1,
    REG_FRAC_A_PLUS  = 3'd2,
    REG_FRAC_A_MINUS = 3'd3,
    REG_FRAC_B_PLUS  = 3'd4
  } reg_idx_t;

  // 1/(16 pi) scaled by 2^40, split into two halves for narrower multiplies
  localparam logic [34:0] INV16PI_K = 35'd21874088818;
  localparam int          K_SPLIT   = 17;
  localparam logic [17:0] K_HI      = INV16PI_K[34:17];
  localparam logic [16:0] K_LO      = INV16PI_K[16:0];

  localparam logic signed [63:0] S_CLAMP = 64'sd18014398509481984;  // 2^54
  localparam logic signed [30:0] ONE28   = 31'sd268435456;
  localparam logic signed [26:0] ONE24   = 27'sd16777216;

  // bit0: first angle integrated, bit1: second, bit2: third
  function automatic logic [2:0] integ_mask(input logic [2:0] op);
    logic [2:0] m;
    case (op)
      OP_DENSITY:  m = 3'b000;
      OP_PRIM_C0:  m = 3'b001;
      OP_PRIM_C1:  m = 3'b010;
      OP_PRIM_C2:  m = 3'b100;
      OP_PRIM_C01: m = 3'b011;
      OP_PRIM_C02: m = 3'b101;
      OP_PRIM_C12: m = 3'b110;
      default:     m = 3'b111;
    endcase
    return m;
  endfunction

  // arithmetic shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
    logic signed [63:0] t;
    t = x + (64'sd1 <<< (s - 1));
    if (x[63]) t = t - 64'sd1;
    return t >>> s;
  endfunction

endpackage

### rtl/angular_density_polynomial_unit.sv
// ----------------------------------------------------------------------------
// angular_density_polynomial_unit
// Twelve-stage pipeline: three-angle decay density or primitive, Q1.31 out.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | content
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser | cosines, opcode
//  m_*      | out | m_tvalid m_tready m_tdata         | weight
//  cfg_*    | in  | cfg_we cfg_addr cfg_wdata         | fit parameters
//
// One transaction per cycle sustained while m_tready stays high; twelve
// register stages, their depth set by the multiply chain (squares, cube,
// basis products, coefficient products, output scaling).
// Synchronous reset clears all valid bits and the parameter registers.
// Each stage advances when it is empty or the next one advances; a stall
// at m_tready holds every stage from the output back to the first empty one.
module angular_density_polynomial_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cos_first[15:0], cos_second[31:16], cos_third[47:32]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // weight[31:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int NS = 12;

  logic signed [15:0] pol, asy;
  logic [14:0] fap, fam, fbp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pol <= '0;
      asy <= '0;
      fap <= '0;
      fam <= '0;
      fbp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        adp_pkg::REG_POLARISATION: pol <= cfg_wdata;
        adp_pkg::REG_DECAY_ASYM:   asy <= cfg_wdata;
        adp_pkg::REG_FRAC_A_PLUS:  fap <= cfg_wdata[14:0];
        adp_pkg::REG_FRAC_A_MINUS: fam <= cfg_wdata[14:0];
        adp_pkg::REG_FRAC_B_PLUS:  fbp <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // valid and ready chain
  logic [NS:1] v;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = m_tready;
    for (int k = NS; k >= 1; k--) rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= NS; k++) if (rdy[k]) v[k] <= v[k-1];
    end
  end

  assign s_tready = rdy[1];

  // ---- stage 1: squares, P*L, f1 coefficients
  logic signed [15:0] in_c0, in_c1, in_c2;
  assign in_c0 = s_tdata[15:0];
  assign in_c1 = s_tdata[31:16];
  assign in_c2 = s_tdata[47:32];

  logic [2:0] s1_mask;
  logic signed [15:0] s1_c0, s1_c1, s1_c2;
  logic signed [31:0] s1_sq0, s1_sq1, s1_sq2, s1_pl;
  logic signed [18:0] s1_h [8];
  logic signed [18:0] h_next [8];

  always_comb begin
    logic signed [19:0] a, m, b, d;
    a = signed'({5'b0, fap});
    m = signed'({5'b0, fam});
    b = signed'({5'b0, fbp});
    d = 20'sd16384 - a - m - b;
    h_next[0] = 19'sd32768;
    h_next[1] = 19'(20'sd2 * (a - m + b - d));
    h_next[2] = 19'(20'sd2 * (a - m - b + d));
    h_next[3] = 19'(20'sd2 * (a + m - b - d));
    h_next[4] = 19'(-20'sd2 * a - 20'sd2 * m + b + d);
    h_next[5] = 19'(-20'sd2 * a + 20'sd2 * m + b - d);
    h_next[6] = 19'(-20'sd2 * a + 20'sd2 * m - b + d);
    h_next[7] = 19'(-20'sd2 * a - 20'sd2 * m - b - d);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_mask <= adp_pkg::integ_mask(s_tuser);
      s1_c0   <= in_c0;
      s1_c1   <= in_c1;
      s1_c2   <= in_c2;
      s1_sq0  <= 32'(in_c0) * 32'(in_c0);
      s1_sq1  <= 32'(in_c1) * 32'(in_c1);
      s1_sq2  <= 32'(in_c2) * 32'(in_c2);
      s1_pl   <= 32'(pol) * 32'(asy);
      s1_h    <= h_next;
    end
  end

  // ---- stage 2: basis factors, f1*f2
  logic signed [26:0] s2_fa [2], s2_fb [2];
  logic signed [27:0] s2_fc [2];
  logic signed [49:0] s2_he [8];
  logic signed [26:0] fa_next [2], fb_next [2];
  logic signed [27:0] fc_next [2];
  logic signed [49:0] he_next [8];

  always_comb begin
    logic signed [30:0] e [4];
    logic signed [47:0] cube, lin;
    logic signed [33:0] leg;
    e[0] = adp_pkg::ONE28;
    e[1] = 31'(pol) <<< 14;
    e[2] = 31'(asy) <<< 14;
    e[3] = 31'(s1_pl);
    for (int i = 0; i < 8; i++) he_next[i] = 50'(s1_h[i]) * 50'(e[i % 4]);

    if (s1_mask[0]) begin
      fa_next[0] = 27'(s1_c0) <<< 10;
      fa_next[1] = 27'(adp_pkg::rshr(64'(s1_sq0), 5));
    end else begin
      fa_next[0] = adp_pkg::ONE24;
      fa_next[1] = 27'(s1_c0) <<< 10;
    end
    if (s1_mask[1]) begin
      fb_next[0] = 27'(s1_c1) <<< 10;
      fb_next[1] = 27'(adp_pkg::rshr(64'(s1_sq1), 5));
    end else begin
      fb_next[0] = adp_pkg::ONE24;
      fb_next[1] = 27'(s1_c1) <<< 10;
    end
    cube = 48'(s1_sq2) * 48'(s1_c2);
    lin  = 48'(s1_c2) <<< 28;
    leg  = 34'(s1_sq2) * 34'sd3 - 34'(adp_pkg::ONE28);
    if (s1_mask[2]) begin
      fc_next[0] = 28'(s1_c2) <<< 10;
      fc_next[1] = 28'(adp_pkg::rshr(64'(cube - lin), 19));
    end else begin
      fc_next[0] = 28'(adp_pkg::ONE24);
      fc_next[1] = 28'(adp_pkg::rshr(64'(leg), 5));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_fa <= fa_next;
      s2_fb <= fb_next;
      s2_fc <= fc_next;
      s2_he <= he_next;
    end
  end

  // ---- stage 3: u*v, coefficient rounding
  logic signed [27:0] s3_uv [4];
  logic signed [27:0] s3_fc [2];
  logic signed [30:0] s3_g [8];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < 4; j++)
        s3_uv[j] <= 28'(adp_pkg::rshr(64'(54'(s2_fa[j % 2]) * 54'(s2_fb[j / 2])), 24));
      for (int i = 0; i < 8; i++)
        s3_g[i] <= 31'(adp_pkg::rshr(64'(s2_he[i]), 19));
      s3_fc <= s2_fc;
    end
  end

  // ---- stage 4: basis terms
  logic signed [30:0] s4_b [8];
  logic signed [30:0] s4_g [8];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 8; i++)
        s4_b[i] <= 31'(adp_pkg::rshr(64'(56'(s3_uv[i % 4]) * 56'(s3_fc[i / 4])), 24));
      s4_g <= s3_g;
    end
  end

  // ---- stage 5: term products
  logic signed [61:0] s5_p [8];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 8; i++) s5_p[i] <= 62'(s4_g[i]) * 62'(s4_b[i]);
    end
  end

  // ---- stage 6, 7: sum
  logic signed [63:0] s6_q [4];
  logic signed [63:0] s7_sum;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int k = 0; k < 4; k++) s6_q[k] <= 64'(s5_p[2*k]) + 64'(s5_p[2*k+1]);
    end
    if (rdy[7]) s7_sum <= s6_q[0] + s6_q[1] + s6_q[2] + s6_q[3];
  end

  // ---- stage 8: clamp, magnitude
  logic        s8_neg;
  logic [26:0] s8_uh;
  logic [27:0] s8_ul;
  logic signed [63:0] sc;
  logic [54:0] mag;

  always_comb begin
    if (s7_sum > adp_pkg::S_CLAMP) sc = adp_pkg::S_CLAMP;
    else if (s7_sum < -adp_pkg::S_CLAMP) sc = -adp_pkg::S_CLAMP;
    else sc = s7_sum;
    mag = s7_sum[63] ? 55'(-sc) : 55'(sc);
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_neg <= s7_sum[63];
      s8_uh  <= mag[54:28];
      s8_ul  <= mag[27:0];
    end
  end

  // ---- stage 9: scaling partial products
  logic        s9_neg;
  logic [44:0] s9_hh;
  logic [43:0] s9_hl;
  logic [45:0] s9_lh;
  logic [44:0] s9_ll;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_neg <= s8_neg;
      s9_hh  <= 45'(s8_uh) * 45'(adp_pkg::K_HI);
      s9_hl  <= 44'(s8_uh) * 44'(adp_pkg::K_LO);
      s9_lh  <= 46'(s8_ul) * 46'(adp_pkg::K_HI);
      s9_ll  <= 45'(s8_ul) * 45'(adp_pkg::K_LO);
    end
  end

  // ---- stage 10, 11: recombine
  logic        s10_neg, s11_neg;
  logic [63:0] s10_hi, s10_lo, s11_r;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_neg <= s9_neg;
      s10_hi  <= (64'(s9_hh) << adp_pkg::K_SPLIT) + 64'(s9_hl);
      s10_lo  <= (64'(s9_lh) << adp_pkg::K_SPLIT) + 64'(s9_ll);
    end
    if (rdy[11]) begin
      s11_neg <= s10_neg;
      s11_r   <= s10_hi + (s10_lo >> 28);
    end
  end

  // ---- stage 12: round, sign, saturate
  logic [63:0] rr;
  logic [31:0] w_next;
  logic [31:0] s12_w;

  always_comb begin
    rr = (s11_r + 64'd268435456) >> 29;
    if (s11_neg) w_next = (rr > 64'd2147483648) ? 32'h8000_0000 : 32'(-rr);
    else         w_next = (rr > 64'd2147483647) ? 32'h7FFF_FFFF : rr[31:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[12]) s12_w <= w_next;
  end

  assign m_tvalid = v[NS];
  assign m_tdata  = s12_w;

`ifndef NO_ASSERTIONS
  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output stage");

  a_sink_ready_flows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready) else $error("pipeline stalled while sink ready");

  a_reset_flushes: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("output valid right after reset");
`endif

endmodule
